/* src/sgb_pkg.sv */
// ----------------------------------------------------------------------------
// Scatter-gather builder package
// Shared types, register indexes and status codes of the list builder.
// ----------------------------------------------------------------------------
package sgb_pkg;

  localparam int InDataW  = 96;
  localparam int OutDataW = 136;
  localparam int PageIdxW = 20;

  localparam int ResDepth = 8;
  localparam int ResPtrW  = $clog2(ResDepth);

  localparam logic [7:0] CFG_WINDOW_OFFSET    = 8'd0;
  localparam logic [7:0] CFG_WINDOW_LENGTH    = 8'd1;
  localparam logic [7:0] CFG_DIRECTION_WRITE  = 8'd2;
  localparam logic [7:0] CFG_ELEMENT_CAPACITY = 8'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_RANGE    = 2'd1;
  localparam logic [1:0] ST_CAPACITY = 2'd2;

  // One page chunk of the window, as handed from the segment tracker to the
  // element builder.
  typedef struct packed {
    logic        active;
    logic [63:0] addr;
    logic [31:0] chunk;
    logic        chain_end;
    logic        range_bad;
  } sgb_chunk_t;

  typedef struct packed {
    logic [63:0] address;
    logic [31:0] length;
    logic        write;
    logic        is_status;
    logic [1:0]  code;
    logic [31:0] total;
    logic        last;
  } sgb_result_t;

endpackage

/* src/sgb_segment.sv */
// ----------------------------------------------------------------------------
// Scatter-gather builder segment tracker
// Cuts the byte window out of the chain and yields at most one page chunk per entry.
// ----------------------------------------------------------------------------
module sgb_segment import sgb_pkg::*; #(
  parameter int PAGE_BITS = 12
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             take_item,
  input  logic [51:0]      page_frame,
  input  logic             segment_first,
  input  logic [11:0]      segment_start_offset,
  input  logic [31:0]      segment_bytes,
  input  logic             chain_end,
  input  logic [31:0]      window_offset,
  input  logic [31:0]      window_length,
  output sgb_chunk_t       chunk_out
);

  localparam logic [PAGE_BITS:0] PageSize = (PAGE_BITS + 1)'(1) << PAGE_BITS;

  logic                in_chain;
  logic [31:0]         offset_left;
  logic [31:0]         length_left;
  logic [PageIdxW-1:0] page_in_segment;
  logic [32:0]         seg_start;
  logic [31:0]         seg_left;
  logic                missing;

  logic [31:0]          offset_left_next;
  logic [31:0]          length_left_next;
  logic [PageIdxW-1:0]  page_in_segment_next;
  logic [32:0]          seg_start_next;
  logic [31:0]          seg_left_next;
  logic                 missing_next;
  logic [31:0]          avail;
  logic [31:0]          take_len;
  logic [63:0]          start_ext;
  logic                 hit;
  logic [PAGE_BITS-1:0] in_page;
  logic [PAGE_BITS:0]   room;
  logic [31:0]          chunk;
  sgb_chunk_t           chunk_next;

  always_comb begin
    offset_left_next     = in_chain ? offset_left : window_offset;
    length_left_next     = in_chain ? length_left : window_length;
    page_in_segment_next = in_chain ? page_in_segment : '0;
    seg_start_next       = in_chain ? seg_start : '0;
    seg_left_next        = in_chain ? seg_left : '0;
    missing_next         = in_chain ? missing : 1'b0;
    avail                = '0;
    take_len             = '0;

    if (segment_first) begin
      missing_next         = missing_next | (seg_left_next != '0);
      page_in_segment_next = '0;
      if (offset_left_next >= segment_bytes) begin
        offset_left_next = offset_left_next - segment_bytes;
        seg_start_next   = '0;
        seg_left_next    = '0;
      end else begin
        avail            = segment_bytes - offset_left_next;
        take_len         = (length_left_next < avail) ? length_left_next : avail;
        seg_start_next   = 33'(segment_start_offset) + 33'(offset_left_next);
        seg_left_next    = take_len;
        offset_left_next = '0;
        length_left_next = length_left_next - take_len;
      end
    end

    start_ext = 64'(seg_start_next);
    hit       = (seg_left_next != '0) &&
                (start_ext[PAGE_BITS +: PageIdxW] == page_in_segment_next);
    in_page   = seg_start_next[PAGE_BITS-1:0];
    room      = PageSize - {1'b0, in_page};
    chunk     = (32'(room) < seg_left_next) ? 32'(room) : seg_left_next;

    chunk_next.active    = hit;
    chunk_next.addr      = 64'({page_frame, in_page});
    chunk_next.chunk     = chunk;
    chunk_next.chain_end = chain_end;
    chunk_next.range_bad = 1'b0;

    if (hit) begin
      seg_start_next = seg_start_next + 33'(chunk);
      seg_left_next  = seg_left_next - chunk;
    end
    page_in_segment_next = page_in_segment_next + PageIdxW'(1);

    if (chain_end) begin
      missing_next         = missing_next | (seg_left_next != '0);
      chunk_next.range_bad = (offset_left_next != '0) || (length_left_next != '0) ||
                             missing_next;
      seg_left_next        = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_chain <= 1'b0;
    end else if (take_item) begin
      in_chain <= !chain_end;
    end
  end

  always_ff @(posedge clk) begin
    if (take_item) begin
      offset_left     <= offset_left_next;
      length_left     <= length_left_next;
      page_in_segment <= page_in_segment_next;
      seg_start       <= seg_start_next;
      seg_left        <= seg_left_next;
      missing         <= missing_next;
      chunk_out       <= chunk_next;
    end
  end

endmodule

/* src/sgb_element.sv */
// ----------------------------------------------------------------------------
// Scatter-gather builder element stage
// Merges adjacent chunks into the open element and forms element and status
// results.
// ----------------------------------------------------------------------------
module sgb_element import sgb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        fire,
  input  sgb_chunk_t  chunk_in,
  input  logic        direction_write,
  input  logic [15:0] element_capacity,
  output sgb_result_t res0,
  output sgb_result_t res1,
  output sgb_result_t res2,
  output logic [2:0]  res_valid
);

  logic        pend_valid;
  logic [63:0] pend_addr;
  logic [31:0] pend_len;
  logic [63:0] pend_end;
  logic [31:0] elem_count;

  logic        pend_valid_next;
  logic [63:0] pend_addr_next;
  logic [31:0] pend_len_next;
  logic [63:0] pend_end_next;
  logic [31:0] elem_count_next;
  logic [32:0] sum;
  logic        merge;

  always_comb begin
    pend_valid_next = pend_valid;
    pend_addr_next  = pend_addr;
    pend_len_next   = pend_len;
    pend_end_next   = pend_end;
    elem_count_next = elem_count;
    res_valid       = 3'b000;
    res0            = '0;
    res1            = '0;
    res2            = '0;
    sum             = {1'b0, pend_len} + {1'b0, chunk_in.chunk};
    merge           = pend_valid && (pend_end == chunk_in.addr) && !sum[32];

    if (chunk_in.active) begin
      if (merge) begin
        pend_len_next = sum[31:0];
        pend_end_next = pend_end + 64'(chunk_in.chunk);
      end else begin
        res_valid[0]  = pend_valid && (elem_count <= 32'(element_capacity));
        res0.address  = pend_addr;
        res0.length   = pend_len;
        res0.write    = direction_write;
        res0.last     = !chunk_in.chain_end;
        if (elem_count != '1) begin
          elem_count_next = elem_count + 32'd1;
        end
        pend_valid_next = 1'b1;
        pend_addr_next  = chunk_in.addr;
        pend_len_next   = chunk_in.chunk;
        pend_end_next   = chunk_in.addr + 64'(chunk_in.chunk);
      end
    end

    if (chunk_in.chain_end) begin
      res_valid[1] = pend_valid_next && (elem_count_next <= 32'(element_capacity));
      res1.address = pend_addr_next;
      res1.length  = pend_len_next;
      res1.write   = direction_write;
      res_valid[2]   = 1'b1;
      res2.is_status = 1'b1;
      res2.last      = 1'b1;
      if (chunk_in.range_bad) begin
        res2.code = ST_RANGE;
      end else if (elem_count_next > 32'(element_capacity)) begin
        res2.code  = ST_CAPACITY;
        res2.total = elem_count_next;
      end else begin
        res2.code  = ST_OK;
        res2.total = elem_count_next;
      end
      pend_valid_next = 1'b0;
      elem_count_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      elem_count <= '0;
    end else if (fire) begin
      pend_valid <= pend_valid_next;
      elem_count <= elem_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      pend_addr <= pend_addr_next;
      pend_len  <= pend_len_next;
      pend_end  <= pend_end_next;
    end
  end

endmodule

/* src/dma_scatter_gather_builder_unit.sv */
// ----------------------------------------------------------------------------
// DMA scatter-gather list builder
// Turns a stream of page entries into scatter-gather elements and a status.
// ----------------------------------------------------------------------------
// One page entry is taken per cycle while s_tready is high. An entry is
// registered in the segment tracker, passes the element stage once the
// queue has room and lands in an eight-entry result queue. An entry yields
// at most one result except at chain end, where it can yield up to three
// (a closed element, the final element and the status); the queue drains
// one result per cycle while m_tready is high, and an entry waits in the
// tracker while the queue holds more than five results, so new entries
// stall once one is waiting there. Configuration is written through the
// cfg port, which is always ready.
module dma_scatter_gather_builder_unit import sgb_pkg::*; #(
  parameter int PAGE_BITS = 12
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  // page_frame [51:0], segment_start_offset [63:52], segment_bytes [95:64]
  input  logic [InDataW-1:0]  s_tdata,
  // segment_first [0]
  input  logic                s_tuser,
  input  logic                s_tlast,
  output logic                m_tvalid,
  input  logic                m_tready,
  // element_address [63:0], element_length [95:64], element_write [96],
  // status_code [98:97], total_elements [130:99], zero fill [135:131]
  output logic [OutDataW-1:0] m_tdata,
  // is_status [0]
  output logic                m_tuser,
  output logic                m_tlast,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [7:0]          cfg_index,
  input  logic [31:0]         cfg_data
);

  logic [31:0] window_offset;
  logic [31:0] window_length;
  logic        direction_write;
  logic [15:0] element_capacity;

  logic        take_item;
  logic        s1_valid;
  logic        s2_take;
  logic        fire;
  sgb_chunk_t  s1_chunk;

  sgb_result_t res0;
  sgb_result_t res1;
  sgb_result_t res2;
  logic [2:0]  res_valid;
  logic [2:0]  wr_valid;

  sgb_result_t        q_mem [ResDepth];
  logic [ResPtrW-1:0] wr_ptr;
  logic [ResPtrW-1:0] rd_ptr;
  logic [ResPtrW:0]   q_count;
  logic [ResPtrW-1:0] wr_pos1;
  logic [ResPtrW-1:0] wr_pos2;
  logic [1:0]         n_wr;
  logic               pop;
  sgb_result_t        head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_offset    <= '0;
      window_length    <= '0;
      direction_write  <= 1'b0;
      element_capacity <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_WINDOW_OFFSET:    window_offset    <= cfg_data;
        CFG_WINDOW_LENGTH:    window_length    <= cfg_data;
        CFG_DIRECTION_WRITE:  direction_write  <= cfg_data[0];
        CFG_ELEMENT_CAPACITY: element_capacity <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  assign s2_take   = q_count <= (ResPtrW + 1)'(ResDepth - 3);
  assign fire      = s1_valid && s2_take;
  assign s_tready  = !s1_valid || s2_take;
  assign take_item = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= take_item || (s1_valid && !s2_take);
    end
  end

  sgb_segment #(
    .PAGE_BITS (PAGE_BITS)
  ) u_segment (
    .clk                  (clk),
    .rst                  (rst),
    .take_item            (take_item),
    .page_frame           (s_tdata[51:0]),
    .segment_first        (s_tuser),
    .segment_start_offset (s_tdata[63:52]),
    .segment_bytes        (s_tdata[95:64]),
    .chain_end            (s_tlast),
    .window_offset        (window_offset),
    .window_length        (window_length),
    .chunk_out            (s1_chunk)
  );

  sgb_element u_element (
    .clk              (clk),
    .rst              (rst),
    .fire             (fire),
    .chunk_in         (s1_chunk),
    .direction_write  (direction_write),
    .element_capacity (element_capacity),
    .res0             (res0),
    .res1             (res1),
    .res2             (res2),
    .res_valid        (res_valid)
  );

  assign wr_valid = fire ? res_valid : 3'b000;
  assign n_wr     = 2'(wr_valid[0]) + 2'(wr_valid[1]) + 2'(wr_valid[2]);
  assign wr_pos1  = wr_ptr + ResPtrW'(wr_valid[0]);
  assign wr_pos2  = wr_pos1 + ResPtrW'(wr_valid[1]);
  assign pop      = m_tvalid && m_tready;

  always_ff @(posedge clk) begin
    if (wr_valid[0]) begin
      q_mem[wr_ptr] <= res0;
    end
    if (wr_valid[1]) begin
      q_mem[wr_pos1] <= res1;
    end
    if (wr_valid[2]) begin
      q_mem[wr_pos2] <= res2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      q_count <= '0;
    end else begin
      wr_ptr  <= wr_ptr + ResPtrW'(n_wr);
      rd_ptr  <= rd_ptr + ResPtrW'(pop);
      q_count <= q_count + (ResPtrW + 1)'(n_wr) - (ResPtrW + 1)'(pop);
    end
  end

  assign head     = q_mem[rd_ptr];
  assign m_tvalid = q_count != '0;
  assign m_tdata  = {5'b0, head.total, head.code, head.write, head.length, head.address};
  assign m_tuser  = head.is_status;
  assign m_tlast  = head.last;

endmodule

/* src/sgb_checker.sv */
// ----------------------------------------------------------------------------
// Scatter-gather builder port checker
// Watches the result stream of the list builder and flags malformed results.
// ----------------------------------------------------------------------------
module sgb_checker import sgb_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                m_tvalid,
  input logic                m_tready,
  input logic [OutDataW-1:0] m_tdata,
  input logic                m_tuser,
  input logic                m_tlast
);

  // A stalled result stays offered unchanged.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // The status closes the results of its request.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tlast)
    else $error("status result without tlast");

  // Status codes stay within the defined set.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[98:97] != 2'd3)
    else $error("undefined status code");

  // Element results carry no status code and no count.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata[130:97] == '0)
    else $error("element result with status fields set");

  // An invalid window range reports no element count.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser && m_tdata[98:97] == ST_RANGE |-> m_tdata[130:99] == '0)
    else $error("invalid range status with nonzero count");

endmodule

bind dma_scatter_gather_builder_unit sgb_checker u_sgb_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

/* verif/tb_dma_scatter_gather_builder_unit.sv */
// ----------------------------------------------------------------------------
// Scatter-gather list builder testbench
// Feeds chains of page entries through the builder under random flow control
// and checks every element and status against a behavioral model of the
// window cut, page split and merge rules.
// ----------------------------------------------------------------------------
module tb_dma_scatter_gather_builder_unit;
  import sgb_pkg::*;

  localparam int PAGE_BITS = 12;
  localparam int PAGE_BYTES = 1 << PAGE_BITS;
  localparam int RANDOM_ITEMS = 420;
  localparam int PRESSURE_CHAIN = 12;
  localparam int HOLD_CYCLES = 300;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct packed {
    logic [51:0] frame;
    logic        first;
    logic [11:0] start_off;
    logic [31:0] seg_bytes;
    logic        chain_end;
  } page_entry_t;

  typedef enum logic {ROW_CFG, ROW_PAGE} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [7:0]  reg_index;
    logic [31:0] reg_value;
    page_entry_t entry;
    logic        has_status;
    logic [1:0]  status;
    logic [31:0] total;
  } stim_row_t;

  typedef struct packed {
    logic [1:0]  code;
    logic [31:0] total;
  } status_note_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [InDataW-1:0]  s_tdata = '0;
  logic                s_tuser = 1'b0;
  logic                s_tlast = 1'b0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OutDataW-1:0] m_tdata;
  logic                m_tuser;
  logic                m_tlast;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [7:0]          cfg_index = '0;
  logic [31:0]         cfg_data = '0;

  always #1 clk = ~clk;

  dma_scatter_gather_builder_unit #(.PAGE_BITS(PAGE_BITS)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  logic [31:0] cfg_offset = '0;
  logic [31:0] cfg_length = '0;
  logic        cfg_write_dir = 1'b0;
  logic [15:0] cfg_capacity = '0;

  logic [31:0] skip_left = '0;
  logic [31:0] map_left = '0;
  logic [19:0] page_index = '0;
  logic [32:0] seg_cursor = '0;
  logic [31:0] seg_due = '0;
  logic [63:0] open_addr = '0;
  logic [31:0] open_len = '0;
  logic        open_valid = 1'b0;
  logic [31:0] elem_count = '0;
  logic        chain_open = 1'b0;
  logic        lost_bytes = 1'b0;

  sgb_result_t  expected_results[$];
  sgb_result_t  step_results[$];
  status_note_t typed_status[$];
  page_entry_t  chain_entries[$];
  stim_row_t    directed_rows[$];

  int  mismatch_count = 0;
  int  stall_cycles = 0;
  bit  tx_steady = 1'b0;
  bit  rx_steady = 1'b0;
  bit  hold_request = 1'b0;

  function automatic stim_row_t cfg_row(input logic [7:0] idx, input logic [31:0] value);
    stim_row_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.reg_index = idx;
    r.reg_value = value;
    return r;
  endfunction

  function automatic stim_row_t page_row(input logic [51:0] frame, input logic first,
                                         input logic [11:0] soff, input logic [31:0] nbytes);
    stim_row_t r;
    r = '0;
    r.kind = ROW_PAGE;
    r.entry = '{frame, first, soff, nbytes, 1'b0};
    return r;
  endfunction

  function automatic stim_row_t end_row(input logic [51:0] frame, input logic first,
                                        input logic [11:0] soff, input logic [31:0] nbytes,
                                        input logic [1:0] code, input logic [31:0] total);
    stim_row_t r;
    r = page_row(frame, first, soff, nbytes);
    r.entry.chain_end = 1'b1;
    r.has_status = 1'b1;
    r.status = code;
    r.total = total;
    return r;
  endfunction

  function automatic logic [31:0] corner_word();
    case ($urandom_range(0, 2))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  function automatic void close_open();
    sgb_result_t r;
    if (open_valid && elem_count <= 32'(cfg_capacity)) begin
      r = '0;
      r.address = open_addr;
      r.length = open_len;
      r.write = cfg_write_dir;
      r.code = ST_OK;
      step_results.push_back(r);
    end
    open_valid = 1'b0;
  endfunction

  function automatic void predict_entry(input page_entry_t e);
    logic [31:0]          avail;
    logic [31:0]          take;
    logic [31:0]          chunk;
    logic [32:0]          room;
    logic [PAGE_BITS-1:0] in_page;
    logic [63:0]          addr;
    sgb_result_t          r;
    step_results.delete();
    if (!chain_open) begin
      skip_left = cfg_offset;
      map_left = cfg_length;
      page_index = '0;
      seg_cursor = '0;
      seg_due = '0;
      open_addr = '0;
      open_len = '0;
      open_valid = 1'b0;
      elem_count = '0;
      lost_bytes = 1'b0;
      chain_open = 1'b1;
    end
    if (e.first) begin
      if (seg_due != 0) lost_bytes = 1'b1;
      page_index = '0;
      if (skip_left >= e.seg_bytes) begin
        skip_left = skip_left - e.seg_bytes;
        seg_cursor = '0;
        seg_due = '0;
      end else begin
        avail = e.seg_bytes - skip_left;
        take = (map_left < avail) ? map_left : avail;
        seg_cursor = 33'(e.start_off) + 33'(skip_left);
        seg_due = take;
        skip_left = '0;
        map_left = map_left - take;
      end
    end
    if (seg_due != 0 && seg_cursor[PAGE_BITS +: 20] == page_index) begin
      in_page = seg_cursor[PAGE_BITS-1:0];
      room = 33'(PAGE_BYTES) - 33'(in_page);
      chunk = (room < 33'(seg_due)) ? room[31:0] : seg_due;
      addr = (64'(e.frame) << PAGE_BITS) + 64'(in_page);
      if (open_valid && (open_addr + 64'(open_len)) == addr &&
          (33'(open_len) + 33'(chunk)) <= 33'h0_FFFF_FFFF) begin
        open_len = open_len + chunk;
      end else begin
        close_open();
        if (elem_count != 32'hFFFF_FFFF) elem_count = elem_count + 32'd1;
        open_valid = 1'b1;
        open_addr = addr;
        open_len = chunk;
      end
      seg_cursor = seg_cursor + 33'(chunk);
      seg_due = seg_due - chunk;
    end
    page_index = page_index + 20'd1;
    if (e.chain_end) begin
      close_open();
      if (seg_due != 0) lost_bytes = 1'b1;
      r = '0;
      r.is_status = 1'b1;
      if (skip_left != 0 || map_left != 0 || lost_bytes) begin
        r.code = ST_RANGE;
      end else if (elem_count > 32'(cfg_capacity)) begin
        r.code = ST_CAPACITY;
        r.total = elem_count;
      end else begin
        r.code = ST_OK;
        r.total = elem_count;
      end
      step_results.push_back(r);
      seg_due = '0;
      chain_open = 1'b0;
    end
    if (step_results.size() != 0) begin
      r = step_results.pop_back();
      r.last = 1'b1;
      step_results.push_back(r);
    end
    foreach (step_results[i]) expected_results.push_back(step_results[i]);
  endfunction

  function automatic void report_mismatch(input string what, input sgb_result_t want,
                                          input sgb_result_t got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%s expected: addr=%h len=%h wr=%b st=%b code=%0d total=%0d last=%b", what,
               want.address, want.length, want.write, want.is_status, want.code,
               want.total, want.last);
      $display("%s actual:   addr=%h len=%h wr=%b st=%b code=%0d total=%0d last=%b", what,
               got.address, got.length, got.write, got.is_status, got.code,
               got.total, got.last);
    end
  endfunction

  always @(posedge clk) begin
    sgb_result_t  got;
    sgb_result_t  want;
    status_note_t note;
    page_entry_t  taken;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_WINDOW_OFFSET:    cfg_offset = cfg_data;
          CFG_WINDOW_LENGTH:    cfg_length = cfg_data;
          CFG_DIRECTION_WRITE:  cfg_write_dir = cfg_data[0];
          CFG_ELEMENT_CAPACITY: cfg_capacity = cfg_data[15:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        taken.frame = s_tdata[51:0];
        taken.start_off = s_tdata[63:52];
        taken.seg_bytes = s_tdata[95:64];
        taken.first = s_tuser;
        taken.chain_end = s_tlast;
        predict_entry(taken);
      end
      if (m_tvalid && m_tready) begin
        got.address = m_tdata[63:0];
        got.length = m_tdata[95:64];
        got.write = m_tdata[96];
        got.code = m_tdata[98:97];
        got.total = m_tdata[130:99];
        got.is_status = m_tuser;
        got.last = m_tlast;
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", '0, got);
        end else begin
          want = expected_results.pop_front();
          if (got !== want) report_mismatch("result", want, got);
        end
        if (got.is_status && typed_status.size() != 0) begin
          note = typed_status.pop_front();
          want = got;
          want.code = note.code;
          want.total = note.total;
          if (got.code !== note.code || got.total !== note.total)
            report_mismatch("directed status", want, got);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles == WATCHDOG_LIMIT) begin
      $display("tb_dma_scatter_gather_builder_unit: errors");
      $finish;
    end
  end

  task automatic send_entry(input page_entry_t e);
    int unsigned gap;
    gap = tx_steady ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {e.seg_bytes, e.start_off, e.frame};
    s_tuser <= e.first;
    s_tlast <= e.chain_end;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [7:0] idx, input logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  initial begin
    int unsigned gap;
    while (rst) @(posedge clk);
    forever begin
      if (hold_request) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
      end
      if ($urandom_range(0, 15) == 0) rx_steady = !rx_steady;
      gap = rx_steady ? 0 : $urandom_range(0, 4);
      if (gap != 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
    end
  end

  initial begin
    stim_row_t    row;
    status_note_t note;
    page_entry_t  e;
    bit           scatter;
    bit           counted;
    int unsigned  chain_no;
    int unsigned  items_sent;
    int unsigned  nseg;
    int unsigned  npages;
    logic [51:0]  frame;
    logic [51:0]  frame0;
    logic [11:0]  soff;
    logic [31:0]  nbytes;
    logic [63:0]  span;
    logic [63:0]  phys_next;
    logic [63:0]  chain_bytes;
    logic [31:0]  avail32;
    logic [31:0]  woff;
    logic [31:0]  wlen;
    logic [15:0]  cap;

    directed_rows = '{
      page_row(52'h0, 1'b0, 12'h000, 32'h0000_0000),
      end_row(52'h0, 1'b1, 12'h000, 32'h0000_0000, ST_OK, 32'd0),
      cfg_row(CFG_WINDOW_OFFSET, 32'h0000_0010),
      cfg_row(CFG_WINDOW_LENGTH, 32'h0000_2000),
      cfg_row(CFG_DIRECTION_WRITE, 32'h0000_0001),
      cfg_row(CFG_ELEMENT_CAPACITY, 32'h0000_FFFF),
      page_row(52'h100, 1'b1, 12'hFFF, 32'h0000_3000),
      page_row(52'h101, 1'b0, 12'hFFF, 32'hFFFF_FFFF),
      page_row(52'h102, 1'b0, 12'h000, 32'h0000_0000),
      end_row(52'h103, 1'b0, 12'hFFF, 32'hFFFF_FFFF, ST_OK, 32'd1),
      cfg_row(CFG_WINDOW_OFFSET, 32'h0000_0000),
      cfg_row(CFG_WINDOW_LENGTH, 32'h0000_1800),
      cfg_row(CFG_DIRECTION_WRITE, 32'h0000_0000),
      cfg_row(CFG_ELEMENT_CAPACITY, 32'h0000_0000),
      page_row(52'hF_FFFF_FFFF_FFFF, 1'b1, 12'h800, 32'h0000_1800),
      end_row(52'h0, 1'b0, 12'h000, 32'h0000_0000, ST_CAPACITY, 32'd1),
      cfg_row(CFG_ELEMENT_CAPACITY, 32'h0000_0001),
      page_row(52'h5, 1'b1, 12'h800, 32'h0000_1800),
      end_row(52'h9, 1'b0, 12'h000, 32'h0000_0000, ST_CAPACITY, 32'd2),
      cfg_row(CFG_WINDOW_OFFSET, 32'hFFFF_FFFF),
      cfg_row(CFG_WINDOW_LENGTH, 32'hFFFF_FFFF),
      cfg_row(CFG_ELEMENT_CAPACITY, 32'h0000_FFFF),
      end_row(52'h7, 1'b1, 12'h000, 32'hFFFF_FFFF, ST_RANGE, 32'd0),
      cfg_row(CFG_WINDOW_OFFSET, 32'h0000_0000),
      end_row(52'hABCDE, 1'b1, 12'hABC, 32'hFFFF_FFFF, ST_RANGE, 32'd0),
      cfg_row(CFG_WINDOW_OFFSET, 32'h0000_0100),
      cfg_row(CFG_WINDOW_LENGTH, 32'h0000_1000),
      page_row(52'h33, 1'b0, 12'h5A5, 32'h1234_5678),
      page_row(52'h40, 1'b1, 12'h000, 32'h0000_0080),
      page_row(52'h50, 1'b1, 12'h010, 32'h0000_2000),
      end_row(52'h60, 1'b1, 12'h000, 32'h0000_0010, ST_RANGE, 32'd0),
      cfg_row(CFG_WINDOW_OFFSET, 32'h0000_0000),
      cfg_row(CFG_WINDOW_LENGTH, 32'h0000_1100),
      cfg_row(CFG_DIRECTION_WRITE, 32'h0000_0001),
      page_row(52'h20, 1'b1, 12'hF00, 32'h0000_1100),
      end_row(52'h30, 1'b0, 12'h000, 32'h0000_0000, ST_OK, 32'd2)
    };

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.kind == ROW_CFG) begin
        wait_idle();
        cfg_write(row.reg_index, row.reg_value);
      end else begin
        if (row.has_status) begin
          note.code = row.status;
          note.total = row.total;
          typed_status.push_back(note);
        end
        send_entry(row.entry);
      end
    end

    chain_no = 0;
    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      scatter = (chain_no == PRESSURE_CHAIN);
      chain_entries.delete();
      chain_bytes = '0;

      // Entries ahead of the first segment carry nothing into the list.
      if (!scatter && $urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 2)) begin
          e.frame = 52'({$urandom(), $urandom()});
          e.first = 1'b0;
          e.start_off = 12'($urandom());
          e.seg_bytes = $urandom();
          e.chain_end = 1'b0;
          chain_entries.push_back(e);
        end
      end

      nseg = scatter ? 4 : $urandom_range(1, 4);
      phys_next = '0;
      for (int s = 0; s < nseg; s++) begin
        if (s > 0 && !scatter && $urandom_range(0, 2) == 0) begin
          soff = phys_next[11:0];
          frame = phys_next[63:12];
        end else begin
          soff = 12'($urandom());
          frame = $urandom_range(0, 1) ? 52'({$urandom(), $urandom()}) :
                                         52'($urandom_range(0, 255));
        end
        case ($urandom_range(0, 9))
          0: nbytes = 32'h0;
          1: nbytes = $urandom();
          default: nbytes = $urandom_range(1, 3 * PAGE_BYTES);
        endcase
        if (scatter) nbytes = 3 * PAGE_BYTES;
        frame0 = frame;
        span = (64'(soff) + 64'(nbytes) + PAGE_BYTES - 1) >> PAGE_BITS;
        npages = (span == 0) ? 1 : (span > 8) ? $urandom_range(1, 4) : int'(span);
        if (!scatter && $urandom_range(0, 11) == 0) npages = $urandom_range(1, npages);
        for (int p = 0; p < npages; p++) begin
          e.frame = frame;
          e.first = (p == 0);
          e.start_off = (p == 0) ? soff : 12'($urandom());
          e.seg_bytes = (p == 0) ? nbytes : $urandom();
          e.chain_end = 1'b0;
          chain_entries.push_back(e);
          if (scatter || $urandom_range(0, 3) == 0)
            frame = 52'({$urandom(), $urandom()});
          else
            frame = frame + 1;
        end
        phys_next = (64'(frame0) << PAGE_BITS) + 64'(soff) + 64'(nbytes);
        chain_bytes = chain_bytes + 64'(nbytes);
      end

      if (!scatter && $urandom_range(0, 9) == 0)
        repeat ($urandom_range(0, chain_entries.size() - 1)) void'(chain_entries.pop_back());
      e = chain_entries.pop_back();
      e.chain_end = 1'b1;
      chain_entries.push_back(e);

      if (scatter || $urandom_range(0, 2) != 0) begin
        avail32 = (chain_bytes > 64'h0_FFFF_FFFF) ? 32'hFFFF_FFFF : chain_bytes[31:0];
        case ($urandom_range(0, 9))
          0, 1: begin
            woff = corner_word();
            wlen = corner_word();
          end
          2: begin
            woff = '0;
            wlen = avail32;
          end
          3: begin
            woff = $urandom_range(0, avail32);
            wlen = avail32 - woff + $urandom_range(1, 64);
          end
          default: begin
            woff = $urandom_range(0, avail32);
            wlen = $urandom_range(0, avail32 - woff);
          end
        endcase
        case ($urandom_range(0, 5))
          0: cap = 16'($urandom_range(0, 3));
          1: cap = 16'hFFFF;
          2: cap = 16'($urandom());
          default: cap = 16'($urandom_range(0, 12));
        endcase
        if (scatter) begin
          woff = '0;
          wlen = avail32;
          cap = 16'hFFFF;
        end
        wait_idle();
        cfg_write(CFG_WINDOW_OFFSET, woff);
        cfg_write(CFG_WINDOW_LENGTH, wlen);
        cfg_write(CFG_DIRECTION_WRITE, 32'($urandom_range(0, 1)));
        cfg_write(CFG_ELEMENT_CAPACITY, 32'(cap));
      end

      tx_steady = ($urandom_range(0, 3) == 0) || scatter;
      if (scatter) hold_request = 1'b1;
      counted = 1'b0;
      foreach (chain_entries[i]) begin
        counted = counted || chain_entries[i].first;
        send_entry(chain_entries[i]);
        if (counted) items_sent++;
      end
      chain_no++;
    end

    wait_idle();
    if (mismatch_count == 0 && typed_status.size() == 0) begin
      $display("tb_dma_scatter_gather_builder_unit: clean");
    end else begin
      $display("tb_dma_scatter_gather_builder_unit: errors");
    end
    $finish;
  end

endmodule

/* dma_scatter_gather_builder_unit.f */
src/sgb_pkg.sv
src/sgb_segment.sv
src/sgb_element.sv
src/dma_scatter_gather_builder_unit.sv
src/sgb_checker.sv
verif/tb_dma_scatter_gather_builder_unit.sv
